FILE: rtl/pea_pkg.sv
// pea_pkg: shared types, constants and codes for the phase energy accumulator.
// No dependencies.
`timescale 1ns / 1ps
package pea_pkg;

    localparam int PHASES      = 7;
    localparam int NUM_REGS    = 8;
    localparam int PH_W        = 3;
    localparam int TICK_W      = 32;
    localparam int CUR_W       = 12;
    localparam int ENERGY_W    = 37;
    localparam int IDX_W       = 3;

    localparam logic [IDX_W-1:0] REG_SUPPLY_MV = 3'd7;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_END    = 2'd2,
        OP_REPORT = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [TICK_W-1:0] timestamp;
        logic [PH_W-1:0]   phase;
    } request_t;

    typedef struct packed {
        logic [PH_W-1:0]     previous_phase;
        logic [ENERGY_W-1:0] energy_nj;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHARGE,
        ST_DIV6,
        ST_MUL1,
        ST_MUL2,
        ST_DIVQ,
        ST_DIVR,
        ST_ACC,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture request, previous phase
        logic charge;     // frame clear or charge and phase update
        logic clr_sum;
        logic div6;       // ticks / 6
        logic mul1;       // us * current
        logic mul2;       // * supply
        logic divq;       // quotient digit of / 1e6
        logic divr;       // remainder of that digit
        logic acc;        // sum += quotient, advance index
        logic done;       // drive result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_report;
        logic last_phase;
        logic last_digit;
    } dp_stat_t;

endpackage

FILE: rtl/phase_energy_accumulator.sv
// phase_energy_accumulator: top level, controller plus datapath.
// Depends on pea_pkg, pea_ctrl, pea_datapath.
`timescale 1ns / 1ps
// Per-phase energy meter. Raise start with a request while busy is low; the
// request is taken at that clock edge. One result follows on result with done
// high for a single cycle and must be captured then, since the receiver cannot
// stall. Begin, end and frame start pass through the CHARGE and DONE states,
// and done is registered after DONE; busy is already low in the cycle that
// done is high, so the next request can be taken then. Report charges first,
// then walks the seven accumulators one at a time (divide by 6, two multiplies,
// a two-digit divide by 1e6, accumulate) before DONE. Configuration writes
// land at once and are taken anytime, but should only be made while busy is low.
module phase_energy_accumulator
    import pea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  request_t          request,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CUR_W-1:0]  cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pea_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    pea_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .request      (request),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (done),
        .result       (result)
    );

    // an accepted request always produces busy next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");

    // done only while busy wound down
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

endmodule

FILE: rtl/pea_ctrl.sv
// pea_ctrl: sequencing state machine for the phase energy accumulator.
// Depends on pea_pkg.
`timescale 1ns / 1ps
module pea_ctrl
    import pea_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_CHARGE;
            ST_CHARGE: state_next = stat.is_report ? ST_DIV6 : ST_DONE;
            ST_DIV6:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_DIVQ;
            ST_DIVQ:   state_next = ST_DIVR;
            ST_DIVR:   state_next = stat.last_digit ? ST_ACC : ST_DIVQ;
            ST_ACC:    state_next = stat.last_phase ? ST_DONE : ST_DIV6;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            ST_CHARGE:
            begin
                cmd.charge  = 1'b1;
                cmd.clr_sum = 1'b1;
            end
            ST_DIV6: cmd.div6 = 1'b1;
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            ST_DIVQ: cmd.divq = 1'b1;
            ST_DIVR: cmd.divr = 1'b1;
            ST_ACC:  cmd.acc  = 1'b1;
            ST_DONE: cmd.done = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

FILE: rtl/pea_datapath.sv
// pea_datapath: accumulators, configuration registers and energy arithmetic.
// Depends on pea_pkg.
`timescale 1ns / 1ps
module pea_datapath
    import pea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CUR_W-1:0]  cfg_data,
    input  request_t          request,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic              result_valid,
    output result_t           result
);

    localparam logic [CUR_W-1:0] CUR_RESET [NUM_REGS] = '{
        12'd4090, 12'd2045, 12'd4090, 12'd2045, 12'd4090, 12'd2045, 12'd2045, 12'd1900
    };
    // floor(x / 6) for 32-bit x: x * ceil(2^34 / 6) >> 34
    localparam logic [31:0] RECIP_6     = 32'hAAAA_AAAB;
    // 1e6 = 64 * 15625: drop 6 bits, then two radix-2^18 digit steps, each a
    // 32-bit numerator times ceil(2^45 / 15625) >> 45
    localparam logic [31:0] RECIP_15625 = 32'd2251799814;
    localparam logic [31:0] DIVISOR     = 32'd15625;

    logic [CUR_W-1:0]  cfg_reg [NUM_REGS];
    logic [TICK_W-1:0] ticks_reg [PHASES];
    logic [PH_W-1:0]   cur_phase_reg;
    logic [TICK_W-1:0] last_stamp_reg;
    request_t          req_reg;
    logic [PH_W-1:0]   prev_reg;
    logic [PH_W-1:0]   idx_reg;
    logic [29:0]       us_reg;     // ticks / 6
    logic [41:0]       p1_reg;     // us (30b) * current (12b)
    logic [53:0]       p2_reg;     // * supply (12b)
    logic              step_reg;   // second digit step
    logic [17:0]       qd_reg;     // quotient digit
    logic [13:0]       drem_reg;   // partial remainder, below 15625
    logic [35:0]       quo_reg;
    logic [ENERGY_W-1:0] sum_reg;
    logic              valid_reg;
    logic [TICK_W-1:0] elapsed;
    logic [31:0]       div_num;

    assign elapsed = req_reg.timestamp - last_stamp_reg;
    // top 12 bits of p2 / 64 are below 15625, so they seed the remainder
    assign div_num = step_reg ? {drem_reg, p2_reg[23:6]}
                              : {2'b00, p2_reg[53:42], p2_reg[41:24]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++) cfg_reg[i] <= CUR_RESET[i];
            for (int i = 0; i < PHASES; i++) ticks_reg[i] <= '0;
            cur_phase_reg  <= '0;
            last_stamp_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.done;
            if (cfg_we) cfg_reg[cfg_index] <= cfg_data;
            if (cmd.charge)
            begin
                last_stamp_reg <= req_reg.timestamp;
                if (op_t'(req_reg.op) == OP_FRAME)
                begin
                    for (int i = 0; i < PHASES; i++) ticks_reg[i] <= '0;
                    cur_phase_reg <= '0;
                end
                else
                begin
                    if (32'(cur_phase_reg) < PHASES)
                        ticks_reg[cur_phase_reg] <= ticks_reg[cur_phase_reg] + elapsed;
                    if (op_t'(req_reg.op) != OP_REPORT && 32'(req_reg.phase) < PHASES)
                        cur_phase_reg <= req_reg.phase;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= request;
            prev_reg <= cur_phase_reg;
        end
        if (cmd.clr_sum)
        begin
            sum_reg <= '0;
            idx_reg <= '0;
        end
        if (cmd.div6) us_reg <= 30'((64'(ticks_reg[idx_reg]) * 64'(RECIP_6)) >> 34);
        if (cmd.mul1) p1_reg <= 42'(us_reg) * 42'(cfg_reg[idx_reg]);
        if (cmd.mul2)
        begin
            p2_reg   <= 54'(p1_reg) * 54'(cfg_reg[REG_SUPPLY_MV]);
            step_reg <= 1'b0;
        end
        if (cmd.divq) qd_reg <= 18'((64'(div_num) * 64'(RECIP_15625)) >> 45);
        if (cmd.divr)
        begin
            drem_reg <= 14'(div_num - 32'(qd_reg) * DIVISOR);
            quo_reg  <= {quo_reg[17:0], qd_reg};
            step_reg <= 1'b1;
        end
        if (cmd.acc)
        begin
            sum_reg <= sum_reg + ENERGY_W'(quo_reg);
            idx_reg <= idx_reg + PH_W'(1);
        end
    end

    assign stat.is_report  = (op_t'(req_reg.op) == OP_REPORT);
    assign stat.last_phase = (32'(idx_reg) == PHASES - 1);
    assign stat.last_digit = step_reg;

    assign result_valid         = valid_reg;
    assign result.previous_phase = prev_reg;
    assign result.energy_nj      = (op_t'(req_reg.op) == OP_REPORT) ? sum_reg : '0;

endmodule
